@@ sv/dersig_pkg.sv @@
// Shared types and constants for the DER ECDSA P-256 signature parser.
`default_nettype none
package dersig_pkg;

   localparam int INT_BYTES = 32;
   localparam int IDX_W     = $clog2(INT_BYTES);

   localparam logic [7:0] SEQ_TAG        = 8'h30;
   localparam logic [7:0] SEQ_LEN_MIN    = 8'd68;
   localparam logic [7:0] SEQ_LEN_MAX    = 8'd70;
   localparam logic [7:0] INT_TAG        = 8'h02;
   localparam logic [7:0] INT_LEN_PLAIN  = 8'd32;
   localparam logic [7:0] INT_LEN_PADDED = 8'd33;
   localparam logic [7:0] PAD_BYTE       = 8'h00;

   typedef enum logic [6:0] {
      PH_SEQ_TAG = 7'b0000001,
      PH_SEQ_LEN = 7'b0000010,
      PH_INT_TAG = 7'b0000100,
      PH_INT_LEN = 7'b0001000,
      PH_PAD     = 7'b0010000,
      PH_DATA    = 7'b0100000,
      PH_DONE    = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      ST_DATA        = 3'd0,
      ST_BAD_SEQ_TAG = 3'd1,
      ST_BAD_SEQ_LEN = 3'd2,
      ST_BAD_INT_TAG = 3'd3,
      ST_BAD_INT_LEN = 3'd4,
      ST_BAD_PAD     = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             which_integer;
      logic [IDX_W-1:0] byte_index;
      logic             last;
      status_type       status;
   } rsp_type;

endpackage
`default_nettype wire

@@ sv/dersig_in_stage.sv @@
// Input register stage for request bytes.
`default_nettype none
module dersig_in_stage
   import dersig_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    advance,
   output logic         s1_valid,
   output req_type      s1_data
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    load;

   assign req_ready   = !s1_valid_ff || advance;
   assign load        = req_valid && req_ready;
   assign s1_valid_in = load ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_data_ff <= req_data;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_data_ff;

endmodule
`default_nettype wire

@@ sv/dersig_step.sv @@
// Parser state and per-byte check and emit logic.
`default_nettype none
module dersig_step
   import dersig_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    s1_valid,
   input  wire req_type s1_data,
   input  wire logic    advance,
   output logic         has_result,
   output rsp_type      result
);

   phase_type        phase_ff, phase_in, phase_cur;
   logic             sel_ff, sel_in, sel_cur;
   logic [IDX_W-1:0] count_ff, count_in, count_cur;
   logic             halted_ff, halted_in, halted_cur;
   logic [7:0]       b;
   logic             end_of_int;

   assign b          = s1_data.in_byte;
   // start restarts the parser before this byte is looked at
   assign phase_cur  = s1_data.start_req ? PH_SEQ_TAG : phase_ff;
   assign sel_cur    = s1_data.start_req ? 1'b0 : sel_ff;
   assign count_cur  = s1_data.start_req ? '0 : count_ff;
   assign halted_cur = s1_data.start_req ? 1'b0 : halted_ff;
   assign end_of_int = (count_cur == IDX_W'(INT_BYTES - 1));

   always_comb begin
      phase_in   = phase_cur;
      sel_in     = sel_cur;
      count_in   = count_cur;
      halted_in  = halted_cur;
      has_result = 1'b0;
      result     = '{out_byte: 8'h00, which_integer: 1'b0, byte_index: '0,
                     last: 1'b0, status: ST_DATA};
      if (!halted_cur) begin
         case (phase_cur)
            PH_SEQ_TAG: begin
               if (b != SEQ_TAG) begin
                  halted_in     = 1'b1;
                  has_result    = 1'b1;
                  result.status = ST_BAD_SEQ_TAG;
               end else begin
                  phase_in = PH_SEQ_LEN;
               end
            end
            PH_SEQ_LEN: begin
               if (!(b inside {[SEQ_LEN_MIN:SEQ_LEN_MAX]})) begin
                  halted_in     = 1'b1;
                  has_result    = 1'b1;
                  result.status = ST_BAD_SEQ_LEN;
               end else begin
                  phase_in = PH_INT_TAG;
                  sel_in   = 1'b0;
               end
            end
            PH_INT_TAG: begin
               if (b != INT_TAG) begin
                  halted_in            = 1'b1;
                  has_result           = 1'b1;
                  result.status        = ST_BAD_INT_TAG;
                  result.which_integer = sel_cur;
               end else begin
                  phase_in = PH_INT_LEN;
               end
            end
            PH_INT_LEN: begin
               if (!(b inside {INT_LEN_PLAIN, INT_LEN_PADDED})) begin
                  halted_in            = 1'b1;
                  has_result           = 1'b1;
                  result.status        = ST_BAD_INT_LEN;
                  result.which_integer = sel_cur;
               end else begin
                  count_in = '0;
                  phase_in = (b == INT_LEN_PADDED) ? PH_PAD : PH_DATA;
               end
            end
            PH_PAD: begin
               if (b != PAD_BYTE) begin
                  halted_in            = 1'b1;
                  has_result           = 1'b1;
                  result.status        = ST_BAD_PAD;
                  result.which_integer = sel_cur;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               has_result           = 1'b1;
               result.out_byte      = b;
               result.which_integer = sel_cur;
               result.byte_index    = count_cur;
               result.last          = end_of_int && sel_cur;
               if (end_of_int) begin
                  count_in = '0;
                  if (!sel_cur) begin
                     sel_in   = 1'b1;
                     phase_in = PH_INT_TAG;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  count_in = count_cur + 1'b1;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = phase_cur;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEQ_TAG;
         sel_ff    <= 1'b0;
         count_ff  <= '0;
         halted_ff <= 1'b0;
      end else if (s1_valid && advance) begin
         phase_ff  <= phase_in;
         sel_ff    <= sel_in;
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/dersig_out_stage.sv @@
// Result register stage with downstream handshake.
`default_nettype none
module dersig_out_stage
   import dersig_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    s1_valid,
   input  wire logic    has_result,
   input  wire rsp_type result,
   output logic         advance,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    load;

   assign advance      = !rsp_valid_ff || rsp_ready;
   assign load         = s1_valid && has_result && advance;
   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ sv/der_ecdsa_p256_signature_parser.sv @@
// Top level of the byte-serial DER ECDSA P-256 signature parser.
// A request passes through the input register and then the result register, and
// the result is valid once the result register has taken it.
// Throughput: 1 request per cycle while rsp_ready does not stall a held result.
// Requests that produce no result still pass through the input register.
// Reset (synchronous, active high) empties both registers and sets the parser
// to expect the sequence tag, integer r, count zero, not halted.
`default_nettype none
module der_ecdsa_p256_signature_parser
   import dersig_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_in_byte,
   input  wire logic             req_start_req,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_which_integer,
   output logic [IDX_W-1:0]      rsp_byte_index,
   output logic                  rsp_last,
   output logic [2:0]            rsp_status
);

   req_type req_data, s1_data;
   rsp_type result, rsp_data;
   logic    s1_valid, advance, has_result;

   assign req_data = '{in_byte: req_in_byte, start_req: req_start_req};

   dersig_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (advance),
      .s1_valid  (s1_valid),
      .s1_data   (s1_data)
   );

   dersig_step u_step (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_data    (s1_data),
      .advance    (advance),
      .has_result (has_result),
      .result     (result)
   );

   dersig_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .has_result (has_result),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_out_byte      = rsp_data.out_byte;
   assign rsp_which_integer = rsp_data.which_integer;
   assign rsp_byte_index    = rsp_data.byte_index;
   assign rsp_last          = rsp_data.last;
   assign rsp_status        = rsp_data.status;

endmodule
`default_nettype wire

@@ sv/dersig_checker.sv @@
// Port-level assertions for the signature parser, bound to the top level.
`default_nettype none
module dersig_checker
   import dersig_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [7:0]       rsp_out_byte,
   input wire logic             rsp_which_integer,
   input wire logic [IDX_W-1:0] rsp_byte_index,
   input wire logic             rsp_last,
   input wire logic [2:0]       rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_index) && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DATA |->
         rsp_out_byte == 8'h00 && rsp_byte_index == '0 && !rsp_last)
      else $error("error result carries data fields");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         rsp_status == ST_DATA && rsp_which_integer
         && rsp_byte_index == IDX_W'(INT_BYTES - 1))
      else $error("last mark off the final byte of s");

   a_seq_err_r: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BAD_SEQ_TAG || rsp_status == ST_BAD_SEQ_LEN)
         |-> !rsp_which_integer)
      else $error("sequence error names integer s");

endmodule

bind der_ecdsa_p256_signature_parser dersig_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_which_integer (rsp_which_integer),
   .rsp_byte_index    (rsp_byte_index),
   .rsp_last          (rsp_last),
   .rsp_status        (rsp_status)
);
`default_nettype wire
